>>> rtl/core/dstwb_pkg.sv
// Shared types and constants for the decimal string to wide binary converter.
`default_nettype none

package dstwb_pkg;

  // Longest string that converts without a length error.
  localparam int unsigned MAX_DIGITS = 38;
  localparam int unsigned WORD_COUNT = 2;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned ACC_W      = WORD_COUNT * WORD_W;
  // The count saturates at MAX_DIGITS + 1, so it needs room for that value.
  localparam int unsigned COUNT_W    = $clog2(MAX_DIGITS + 2);

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_DIGITS);

  // ASCII codes that bound the digit range.
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_LONG = 2'd1,
    STATUS_BAD_CHAR = 2'd2
  } status_t;

  // One character request.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } char_req_t;

  // One conversion result.
  typedef struct packed {
    logic [WORD_W-1:0] value_low;
    logic [WORD_W-1:0] value_high;
    status_t           status;
  } result_t;

  // Running state of the string being converted.
  typedef struct packed {
    logic [ACC_W-1:0]   acc;
    logic [COUNT_W-1:0] count;
    logic               bad;
  } conv_state_t;

endpackage : dstwb_pkg

`default_nettype wire

>>> rtl/core/dstwb_digit_step.sv
// Combinational update of the conversion state for one character.
`default_nettype none

module dstwb_digit_step (
  input  dstwb_pkg::conv_state_t state,
  input  logic [7:0]             char_code,
  output dstwb_pkg::conv_state_t state_next,
  output dstwb_pkg::result_t     result
);
  import dstwb_pkg::*;

  logic                is_digit;
  logic [3:0]          digit;
  logic [COUNT_W-1:0]  count_inc;
  logic [ACC_W-1:0]    acc_x10;
  logic                take_digit;
  status_t             status;

  // Classify the character and extract its value. The ASCII digits sit at
  // 0x30..0x39, so the low nibble is the digit value.
  assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign digit    = char_code[3:0];

  // Every character counts; the count stops one past the limit.
  assign count_inc = (state.count <= COUNT_LIMIT) ? state.count + COUNT_W'(1) : state.count;

  // Multiply by ten as eight times plus two times, then add the digit.
  assign acc_x10 = {state.acc[ACC_W-4:0], 3'b000} + {state.acc[ACC_W-2:0], 1'b0}
                 + {{(ACC_W-4){1'b0}}, digit};

  assign take_digit = is_digit && !state.bad && (count_inc <= COUNT_LIMIT);

  // Next running state.
  always_comb begin
    state_next.count = count_inc;
    state_next.bad   = state.bad || !is_digit;
    state_next.acc   = take_digit ? acc_x10 : state.acc;
  end

  // Status and value as they would be reported if this character ends the string.
  always_comb begin
    if (state_next.count > COUNT_LIMIT) begin
      status = STATUS_TOO_LONG;
    end else if (state_next.bad) begin
      status = STATUS_BAD_CHAR;
    end else begin
      status = STATUS_OK;
    end
    result.status = status;
    if (status == STATUS_OK) begin
      result.value_low  = state_next.acc[WORD_W-1:0];
      result.value_high = state_next.acc[ACC_W-1:WORD_W];
    end else begin
      result.value_low  = '0;
      result.value_high = '0;
    end
  end

endmodule : dstwb_digit_step

`default_nettype wire

>>> rtl/core/decimal_string_to_wide_binary_top.sv
// Top level of the decimal string to 128-bit binary converter.
// The char channel carries one ASCII character per request, most significant
// digit first, with last set on the final character of a string. The res
// channel carries one result per string: the value as two 64-bit words and a
// status (ok, too many characters, non-digit character); the value is zero
// whenever the status is not ok.
// Each accepted character updates a 128-bit accumulator in the same cycle
// through a single times-ten-plus-digit adder, so a character can be taken
// every clock. A result appears on res in the cycle after its last character
// is accepted and stays in the output register until taken.
// Throughput is one character per cycle; it is bounded only by the output
// register: char_ready drops while a result waits and res_ready is low, and
// rises again in the cycle the result is taken, so a stalled receiver holds
// off the sender without losing anything.
// Synchronous reset clears the accumulator, the character count, the error
// flag and the output valid; the block is ready in the first cycle after it.
// After each result the running state returns to its reset values.
`default_nettype none

module decimal_string_to_wide_binary_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_ready,
  input  dstwb_pkg::char_req_t  char_data,
  output logic                  res_valid,
  input  logic                  res_ready,
  output dstwb_pkg::result_t    res_data
);
  import dstwb_pkg::*;

  conv_state_t state;
  conv_state_t state_next;
  result_t     step_result;
  logic        char_accept;

  // A request is taken unless a result is stuck in the output register.
  assign char_ready  = !res_valid || res_ready;
  assign char_accept = char_valid && char_ready;

  dstwb_digit_step u_step (
    .state      (state),
    .char_code  (char_data.char_code),
    .state_next (state_next),
    .result     (step_result)
  );

  // Running state: updated per character, cleared at the end of each string.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (char_accept) begin
      if (char_data.last) begin
        state <= '0;
      end else begin
        state <= state_next;
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (char_accept && char_data.last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (char_accept && char_data.last) begin
      res_data <= step_result;
    end
  end

endmodule : decimal_string_to_wide_binary_top

`default_nettype wire

>>> rtl/core/dstwb_checker.sv
// Port-level checks for the converter, bound to the top level.
`default_nettype none

module dstwb_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 char_valid,
  input logic                 char_ready,
  input dstwb_pkg::char_req_t char_data,
  input logic                 res_valid,
  input logic                 res_ready,
  input dstwb_pkg::result_t   res_data
);
  import dstwb_pkg::*;

  // Nothing is offered right after reset.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  // An error result carries a zero value.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status != STATUS_OK |->
      res_data.value_low == '0 && res_data.value_high == '0)
    else $error("error result with nonzero value");

  // The last character of a string yields a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    char_valid && char_ready && char_data.last |=> res_valid)
    else $error("missing result after last character");

endmodule : dstwb_checker

bind decimal_string_to_wide_binary_top dstwb_checker u_dstwb_checker (.*);

`default_nettype wire
